@@ src/tma_pkg.sv @@
package tma_pkg;

    // Ring depth default; the top level hands it down as MAX_WINDOW
    localparam int TMA_MAX_WINDOW = 64;

    // Fixed widths of the word fields
    localparam int TMA_HOURS_W   = 5;
    localparam int TMA_MIN_W     = 6;
    localparam int TMA_SEC_W     = 6;
    localparam int TMA_SAMPLE_W  = 17;
    localparam int TMA_WINLEN_W  = 7;

    // Register map (index = byte address / 4)
    localparam logic TMA_REG_WINDOW_LEN = 1'b0;
    localparam logic [TMA_WINLEN_W-1:0] TMA_WINLEN_RESET = 7'd1;

    // Time conversion constants
    localparam logic [TMA_SAMPLE_W-1:0] TMA_SEC_PER_HOUR = 17'd3600;
    localparam logic [TMA_SAMPLE_W-1:0] TMA_SEC_PER_MIN  = 17'd60;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // latch the input word, read the oldest ring entry
        logic update;    // write the ring, update sum and fill, arm divider
        logic div_step;  // one restoring divide step
        logic out_load;  // move the quotient to the output register
    } tma_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic emit;      // this word completes a full window
        logic div_last;  // final divide step in progress
        logic out_free;  // output register can take a new word
    } tma_status_t;

    // Seconds since midnight; the largest field values still fit 17 bits
    function automatic logic [TMA_SAMPLE_W-1:0] tma_to_sec(
        input logic [TMA_HOURS_W-1:0] h,
        input logic [TMA_MIN_W-1:0]   m,
        input logic [TMA_SEC_W-1:0]   s
    );
        return TMA_SAMPLE_W'(h) * TMA_SEC_PER_HOUR
             + TMA_SAMPLE_W'(m) * TMA_SEC_PER_MIN
             + TMA_SAMPLE_W'(s);
    endfunction

endpackage

@@ src/tma_ctrl.sv @@
module tma_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tma_pkg::tma_status_t status,
    output tma_pkg::tma_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Sequence one word: latch, update window, then divide and hand off if it completes a window
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = status.emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Input is taken only while idle
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");

    // A result is loaded only after the divide finished
    a_out_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> state_reg == ST_OUT)
        else $error("output load outside output state");

    // An accepted word always goes to the window update next
    a_load_update: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_UPDATE)
        else $error("accepted word skipped the update");

endmodule

@@ src/tma_datapath.sv @@
module tma_datapath #(
    parameter int MAX_WINDOW = tma_pkg::TMA_MAX_WINDOW
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tma_pkg::tma_cmd_t                   cmd,
    output tma_pkg::tma_status_t                status,
    input  logic                                in_start_series,
    input  logic [tma_pkg::TMA_HOURS_W-1:0]     in_hours,
    input  logic [tma_pkg::TMA_MIN_W-1:0]       in_minutes,
    input  logic [tma_pkg::TMA_SEC_W-1:0]       in_seconds,
    input  logic                                cfg_we,
    input  logic [tma_pkg::TMA_WINLEN_W-1:0]    cfg_wdata,
    output logic [tma_pkg::TMA_WINLEN_W-1:0]    win_len,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [tma_pkg::TMA_SAMPLE_W-1:0]    out_data
);

    localparam int SmpW = tma_pkg::TMA_SAMPLE_W;
    localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LW   = $clog2(MAX_WINDOW + 1);
    localparam int XW   = LW + 1;
    localparam int SW   = SmpW + $clog2(MAX_WINDOW);
    localparam int CW   = $clog2(SW + 1);
    localparam logic [LW-1:0] MaxLen  = LW'(MAX_WINDOW);
    localparam logic [AW-1:0] LastPos = AW'(MAX_WINDOW - 1);

    logic [tma_pkg::TMA_WINLEN_W-1:0] win_len_reg;
    logic [LW-1:0]   fill_reg;
    logic [SW-1:0]   sum_reg;
    logic [AW-1:0]   wp_reg;
    logic [SmpW-1:0] sample_reg;
    logic            drop_reg;
    logic [SmpW-1:0] old_rd_reg;
    logic [LW:0]     rem_reg;
    logic [SW-1:0]   quo_reg;
    logic [CW-1:0]   cnt_reg;
    logic            out_valid_reg;
    logic [SmpW-1:0] out_data_reg;

    logic [SmpW-1:0] ring_mem [MAX_WINDOW];

    logic [LW-1:0]   eff_len;
    logic [LW-1:0]   fill_next;
    logic [SW-1:0]   sum_next;
    logic [AW-1:0]   old_addr;
    logic [XW-1:0]   wp_x;
    logic [XW-1:0]   len_x;
    logic [LW:0]     rem_sh;
    logic            q_bit;

    // Clamp the window length to 1..MAX_WINDOW
    always_comb begin
        if (win_len_reg == '0) begin
            eff_len = LW'(1);
        end else if (32'(win_len_reg) > 32'(MAX_WINDOW)) begin
            eff_len = MaxLen;
        end else begin
            eff_len = LW'(win_len_reg);
        end
    end

    // Oldest entry of the window, wrapped around the ring
    always_comb begin
        wp_x  = XW'(wp_reg);
        len_x = XW'(eff_len);
        if (wp_x >= len_x) begin
            old_addr = AW'(wp_x - len_x);
        end else begin
            old_addr = AW'(wp_x + XW'(MAX_WINDOW) - len_x);
        end
    end

    // Window update values
    always_comb begin
        fill_next = (fill_reg < eff_len) ? fill_reg + LW'(1) : fill_reg;
        sum_next  = sum_reg - (drop_reg ? SW'(old_rd_reg) : SW'(0)) + SW'(sample_reg);
    end

    // One restoring divide step
    always_comb begin
        rem_sh = {rem_reg[LW-1:0], quo_reg[SW-1]};
        q_bit  = rem_sh >= {1'b0, eff_len};
    end

    // Ring store: read the oldest entry at accept, write the new one at update
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            old_rd_reg <= ring_mem[old_addr];
        end
        if (cmd.update) begin
            ring_mem[wp_reg] <= sample_reg;
        end
    end

    // Window control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg <= tma_pkg::TMA_WINLEN_RESET;
            fill_reg    <= '0;
            sum_reg     <= '0;
            wp_reg      <= '0;
            drop_reg    <= 1'b0;
        end else if (cfg_we) begin
            win_len_reg <= cfg_wdata;
            fill_reg    <= '0;
            sum_reg     <= '0;
        end else if (cmd.load) begin
            drop_reg <= !in_start_series && (fill_reg >= eff_len);
            if (in_start_series) begin
                fill_reg <= '0;
                sum_reg  <= '0;
            end
        end else if (cmd.update) begin
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
            wp_reg   <= (wp_reg == LastPos) ? '0 : wp_reg + AW'(1);
        end
    end

    // Hold the converted sample
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= tma_pkg::tma_to_sec(in_hours, in_minutes, in_seconds);
        end
    end

    // Divider: shift the sum through, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.update) begin
            cnt_reg <= CW'(SW);
        end else if (cmd.div_step && cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            quo_reg <= sum_next;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[SW-2:0], q_bit};
            rem_reg <= q_bit ? rem_sh - {1'b0, eff_len} : rem_sh;
        end
    end

    // Output register: load the quotient, drop it when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= quo_reg[SmpW-1:0];
        end
    end

    assign status.emit     = fill_next >= eff_len;
    assign status.div_last = cnt_reg == CW'(1);
    assign status.out_free = !out_valid_reg || out_ready;

    assign win_len   = win_len_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Fill count never passes the window length
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= eff_len)
        else $error("fill count above window length");

    // Without an eviction the sum grows by exactly the new sample
    a_sum_add: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update && !drop_reg && !cfg_we |=>
            sum_reg == $past(sum_reg) + SW'($past(sample_reg)))
        else $error("window sum update mismatch");

    // Divider is never stepped past its last bit
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> cnt_reg != '0)
        else $error("divide step with no bits left");

    // A loaded result shows up on the output
    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

@@ src/time_moving_average_core.sv @@
// Flow: an accepted word is latched, then the window is updated; a word that completes
// a window then runs the bit-serial divider over SW quotient bits, and its average is
// loaded into the output register once that register is free. A new word is accepted
// only after the last one is done; SW = 17 + clog2(MAX_WINDOW) is the divider width.
// Reset: synchronous, active low; clears window_len to 1, sum, fill count, write
// position and output valid. Ring contents are not cleared and need no clearing pass.
module time_moving_average_core #(
    parameter int MAX_WINDOW = tma_pkg::TMA_MAX_WINDOW
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_start_series,
    input  logic [tma_pkg::TMA_HOURS_W-1:0]     s_hours,
    input  logic [tma_pkg::TMA_MIN_W-1:0]       s_minutes,
    input  logic [tma_pkg::TMA_SEC_W-1:0]       s_seconds,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tma_pkg::TMA_SAMPLE_W-1:0]    m_average_seconds,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    tma_pkg::tma_cmd_t                cmd;
    tma_pkg::tma_status_t             status;
    logic                             cfg_we;
    logic [tma_pkg::TMA_WINLEN_W-1:0] win_len;

    // Decode the register write at the access phase
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[2] == tma_pkg::TMA_REG_WINDOW_LEN);

    // Read back window_len; other addresses read zero
    assign prdata = (paddr[2] == tma_pkg::TMA_REG_WINDOW_LEN)
                    ? {{(32 - tma_pkg::TMA_WINLEN_W){1'b0}}, win_len} : 32'd0;

    tma_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tma_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .in_start_series (s_start_series),
        .in_hours        (s_hours),
        .in_minutes      (s_minutes),
        .in_seconds      (s_seconds),
        .cfg_we          (cfg_we),
        .cfg_wdata       (pwdata[tma_pkg::TMA_WINLEN_W-1:0]),
        .win_len         (win_len),
        .out_ready       (m_ready),
        .out_valid       (m_valid),
        .out_data        (m_average_seconds)
    );

endmodule
